// File: hdl/section_address_translate_unit_assert.svh
// Assertion macros for the section address translation unit.
// Users must declare clock and reset signals in the enclosing module.
`ifndef SECTION_ADDRESS_TRANSLATE_UNIT_ASSERT_SVH
`define SECTION_ADDRESS_TRANSLATE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SAT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/sat_pkg.sv
// Shared types and codes for the section address translation unit.
// No dependencies; used by the interfaces, the cell and the top level.
package sat_pkg;

   localparam int unsigned ADDR_WIDTH  = 32;
   localparam int unsigned KIND_WIDTH  = 2;
   localparam int unsigned INDEX_WIDTH = 4;
   localparam int unsigned COUNT_WIDTH = 5;
   localparam int unsigned STAT_WIDTH  = 2;

   localparam logic [KIND_WIDTH-1:0] KIND_WRITE   = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_V2F     = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_F2V     = 2'd2;

   localparam logic [STAT_WIDTH-1:0] ST_WRITTEN = 2'd0;
   localparam logic [STAT_WIDTH-1:0] ST_HEADER  = 2'd1;
   localparam logic [STAT_WIDTH-1:0] ST_FOUND   = 2'd2;
   localparam logic [STAT_WIDTH-1:0] ST_MISS    = 2'd3;

   typedef logic [ADDR_WIDTH-1:0] addr_type;

   // A transaction in flight along the chain of cells, with its partial result.
   typedef struct packed {
      logic [KIND_WIDTH-1:0]  kind;
      logic [INDEX_WIDTH-1:0] entry_index;
      addr_type               entry_virt_base;
      addr_type               entry_virt_size;
      addr_type               entry_raw_base;
      addr_type               entry_raw_size;
      addr_type               address;
      addr_type               translated;
      logic [STAT_WIDTH-1:0]  status;
      logic [INDEX_WIDTH-1:0] hit_section;
      logic                   done;
   } sat_item_type;

endpackage

// File: hdl/sat_req_if.sv
// Request channel interface of the section address translation unit.
// Depends on sat_pkg for field widths.
interface sat_req_if import sat_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KIND_WIDTH-1:0]  kind;
   logic [INDEX_WIDTH-1:0] entry_index;
   addr_type               entry_virt_base;
   addr_type               entry_virt_size;
   addr_type               entry_raw_base;
   addr_type               entry_raw_size;
   addr_type               address;

   modport source (output valid, kind, entry_index, entry_virt_base, entry_virt_size,
                   entry_raw_base, entry_raw_size, address, input ready);
   modport sink (input valid, kind, entry_index, entry_virt_base, entry_virt_size,
                 entry_raw_base, entry_raw_size, address, output ready);
endinterface

// File: hdl/sat_rsp_if.sv
// Response channel interface of the section address translation unit.
// Depends on sat_pkg for field widths.
interface sat_rsp_if import sat_pkg::*; ();
   logic                   valid;
   logic                   ready;
   addr_type               translated;
   logic [STAT_WIDTH-1:0]  status;
   logic [INDEX_WIDTH-1:0] hit_section;

   modport source (output valid, translated, status, hit_section, input ready);
   modport sink (input valid, translated, status, hit_section, output ready);
endinterface

// File: hdl/sat_cell.sv
// One cell of the section chain: holds one table entry and checks each passing transaction.
// Depends on sat_pkg for the transaction type and codes.
module sat_cell import sat_pkg::*; #(
   parameter int unsigned INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [COUNT_WIDTH-1:0] section_count,
   input  logic                   in_valid,
   input  sat_item_type           in_item,
   output logic                   out_valid,
   output sat_item_type           out_item
);

   localparam bit                     IS_FIRST = (INDEX == 0);
   localparam logic [INDEX_WIDTH-1:0] HIT      = INDEX_WIDTH'(INDEX);

   addr_type     virt_base_ff;
   addr_type     virt_end_ff;
   addr_type     raw_base_ff;
   addr_type     raw_end_ff;
   addr_type     delta_v2f_ff;
   addr_type     delta_f2v_ff;
   logic         valid_ff;
   sat_item_type item_ff;
   sat_item_type item_in;
   logic         is_lookup;
   logic         is_fwd;
   logic         active;
   logic         do_write;
   addr_type     from_base;
   addr_type     from_end;
   addr_type     delta;

   assign active   = (32'(section_count) > 32'(INDEX));
   assign do_write = advance && in_valid && (in_item.kind == KIND_WRITE) &&
                     (32'(in_item.entry_index) == 32'(INDEX));

   // The end of each range and the rebasing offsets are worked out when the entry is written.
   always_ff @(posedge clock) begin
      if (do_write) begin
         virt_base_ff <= in_item.entry_virt_base;
         virt_end_ff  <= in_item.entry_virt_base + in_item.entry_virt_size;
         raw_base_ff  <= in_item.entry_raw_base;
         raw_end_ff   <= in_item.entry_raw_base + in_item.entry_raw_size;
         delta_v2f_ff <= in_item.entry_raw_base - in_item.entry_virt_base;
         delta_f2v_ff <= in_item.entry_virt_base - in_item.entry_raw_base;
      end
   end

   always_comb begin
      is_lookup = (in_item.kind == KIND_V2F) || (in_item.kind == KIND_F2V);
      is_fwd    = (in_item.kind == KIND_V2F);
      from_base = is_fwd ? virt_base_ff : raw_base_ff;
      from_end  = is_fwd ? virt_end_ff : raw_end_ff;
      delta     = is_fwd ? delta_v2f_ff : delta_f2v_ff;
      item_in   = in_item;
      if (is_lookup && !in_item.done) begin
         if (IS_FIRST && (in_item.address < from_base)) begin
            item_in.translated = in_item.address;
            item_in.status     = ST_HEADER;
            item_in.done       = 1'b1;
         end else if (active && (in_item.address >= from_base) &&
                      (in_item.address < from_end)) begin
            item_in.translated  = in_item.address + delta;
            item_in.status      = ST_FOUND;
            item_in.hit_section = HIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: hdl/section_address_translate_unit.sv
// Each request passes through the register of every cell in the chain, in order, before its response is valid.
// Throughput: one transaction per cycle while the response side keeps taking results.
// The chain of cells stalls as a whole when the response register is full and not taken.
// Reset clears the pipeline valid bits and the section count; table entries stay undefined.
// Depends on sat_pkg, sat_req_if, sat_rsp_if, sat_cell and the assertion macro header.
`include "section_address_translate_unit_assert.svh"

module section_address_translate_unit import sat_pkg::*; #(
   parameter int unsigned MAX_SECTIONS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   csr_write_enable,
   input logic [COUNT_WIDTH-1:0] csr_write_data,
   sat_req_if.sink               req_chan,
   sat_rsp_if.source             rsp_chan
);

   logic [COUNT_WIDTH-1:0]  count_ff;
   logic [MAX_SECTIONS:0]   chain_valid;
   sat_item_type            chain_item [MAX_SECTIONS+1];
   logic                    advance;
   logic                    lookup;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   assign advance = !chain_valid[MAX_SECTIONS] || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign lookup = (req_chan.kind == KIND_V2F) || (req_chan.kind == KIND_F2V);

   always_comb begin
      chain_item[0].kind            = req_chan.kind;
      chain_item[0].entry_index     = req_chan.entry_index;
      chain_item[0].entry_virt_base = req_chan.entry_virt_base;
      chain_item[0].entry_virt_size = req_chan.entry_virt_size;
      chain_item[0].entry_raw_base  = req_chan.entry_raw_base;
      chain_item[0].entry_raw_size  = req_chan.entry_raw_size;
      chain_item[0].address         = req_chan.address;
      chain_item[0].translated      = '0;
      chain_item[0].status          = (req_chan.kind == KIND_WRITE) ? ST_WRITTEN : ST_MISS;
      chain_item[0].hit_section     = '0;
      chain_item[0].done            = !lookup;
   end

   assign chain_valid[0] = req_chan.valid;

   for (genvar i = 0; i < MAX_SECTIONS; i++) begin : g_cell
      sat_cell #(
         .INDEX(i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .section_count (count_ff),
         .in_valid      (chain_valid[i]),
         .in_item       (chain_item[i]),
         .out_valid     (chain_valid[i+1]),
         .out_item      (chain_item[i+1])
      );
   end

   assign rsp_chan.valid       = chain_valid[MAX_SECTIONS];
   assign rsp_chan.translated  = chain_item[MAX_SECTIONS].translated;
   assign rsp_chan.status      = chain_item[MAX_SECTIONS].status;
   assign rsp_chan.hit_section = chain_item[MAX_SECTIONS].hit_section;

   `SAT_ASSERT_NOW(a_write_zero, rsp_chan.valid && (rsp_chan.status == ST_WRITTEN),
      (rsp_chan.translated == '0) && (rsp_chan.hit_section == '0),
      "Write response carries a nonzero payload.")
   `SAT_ASSERT_NOW(a_miss_zero, rsp_chan.valid && (rsp_chan.status == ST_MISS),
      (rsp_chan.translated == '0) && (rsp_chan.hit_section == '0),
      "Miss response carries a nonzero payload.")
   `SAT_ASSERT_NOW(a_header_hit, rsp_chan.valid && (rsp_chan.status == ST_HEADER),
      rsp_chan.hit_section == '0, "Header response names a section.")
   `SAT_ASSERT_NEXT(a_stall_hold, !advance, $stable(chain_valid[MAX_SECTIONS:1]),
      "Chain moved during a stall.")

endmodule
